// ----- rtl/ast_pkg.sv -----
package ast_pkg;

  localparam int unsigned MAX_SOURCE_BYTES_DEF = 65536;

  localparam int KIND_W = 4;
  localparam int OFS_W  = 16;
  localparam int END_W  = 17;
  localparam int LINE_W = 16;
  localparam int COL_W  = 16;
  localparam int ERR_W  = 2;
  localparam int TDATA_W = 72;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd0;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_PERIOD  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_COLON   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_EQUAL   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_PERCENT = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DOLLAR  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd10;
  localparam logic [KIND_W-1:0] KIND_CONST   = 4'd11;
  localparam logic [KIND_W-1:0] KIND_COMMENT = 4'd12;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OPEN_WORD  = 2'd2;

  // scan modes
  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_WORD    = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;

  // characters
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // tdata bit positions of the result word
  localparam int TD_START_LO = 0;
  localparam int TD_END_LO   = TD_START_LO + OFS_W;
  localparam int TD_LINE_LO  = TD_END_LO + END_W;
  localparam int TD_COL_LO   = TD_LINE_LO + LINE_W;
  localparam int TD_ERR_LO   = TD_COL_LO + COL_W;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFS_W-1:0]  start_ofs;
    logic [END_W-1:0]  end_ofs;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [ERR_W-1:0]  err;
    logic              last;
  } token_t;

endpackage

// ----- rtl/assembly_source_tokenizer_top.sv -----
// Assembly source tokenizer.
// Input channel (in_*): one source byte per word in in_tdata[7:0]; in_tuser
// high marks end of source (the byte is then ignored).
// Output channel (out_*): one token per word. out_tuser carries the token
// kind, out_tdata the offsets, line, column and error code, and out_tlast
// marks the last token caused by one input word.
// An accepted byte is held in the input register; its tokens then go into the
// output queue register, which drives out_tvalid.
// Throughput: one byte per cycle while each byte makes at most one token and the receiver does not stall.
// A byte that closes an identifier, constant or comment and is itself a
// token makes two tokens; the two-entry output queue drains one per cycle
// while out_tready is high; a later byte then waits until its tokens fit.
// After an error or end of source the block swallows words without output
// until reset.
// Reset: synchronous, clears mode, offsets and counters (line and column 1);
// no clearing pass, the block is ready as soon as reset is released.
// Receiver stall: tokens wait in the queue; the input register keeps taking
// bytes until the queue has no room for the next byte's tokens.
module assembly_source_tokenizer_top #(
  parameter int unsigned MAX_SOURCE_BYTES = ast_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // character
  input  logic        in_tuser,   // end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  // start_offset, end_offset, line_number, column_number, error_code, zero pad
  output logic [ast_pkg::TDATA_W-1:0] out_tdata,
  output logic [ast_pkg::KIND_W-1:0]  out_tuser,  // token_kind
  output logic        out_tlast
);

  localparam int PosW = $clog2(MAX_SOURCE_BYTES + 1);
  localparam logic [ast_pkg::COL_W-1:0] ColMax = '1;
  localparam logic [ast_pkg::LINE_W-1:0] LineMax = '1;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // input register
  logic       inv_r;
  logic [7:0] ichar_r;
  logic       ieos_r;

  // scanner state
  logic [1:0]                  mode_r, mode_nxt;
  logic [ast_pkg::KIND_W-1:0]  pend_r, pend_nxt;
  logic [PosW-1:0]             tstart_r, tstart_nxt;
  logic [PosW-1:0]             pos_r, pos_nxt;
  logic [ast_pkg::LINE_W-1:0]  line_r, line_nxt;
  logic [ast_pkg::COL_W-1:0]   col_r, col_nxt;
  logic                        halt_r, halt_nxt;

  // output queue, slot 0 is the head
  ast_pkg::token_t q_r [2];
  ast_pkg::token_t q_nxt [2];
  logic [1:0]      count_r, count_nxt;

  ast_pkg::token_t res_a, res_b, res0, res1;
  logic            pe, bv, dc, at_end, take, pop;
  logic [1:0]      n_res, base;
  logic [2:0]      need;
  logic [PosW-1:0] pos_p1, len;
  logic [ast_pkg::COL_W-1:0] col_inc, scol;
  logic [ast_pkg::KIND_W-1:0] dkind;

  assign pos_p1  = pos_r + 1'b1;
  assign len     = pos_r - tstart_r;
  assign col_inc = (col_r < ColMax) ? col_r + 1'b1 : col_r;
  assign scol    = (32'(col_r) > 32'(len)) ? ast_pkg::COL_W'(32'(col_r) - 32'(len))
                                           : ast_pkg::COL_W'(1);
  assign at_end  = ieos_r || (pos_r >= PosW'(MAX_SOURCE_BYTES));

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    tstart_nxt = tstart_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    halt_nxt   = halt_r;
    pe = 1'b0;
    bv = 1'b0;
    dc = 1'b0;
    dkind = ast_pkg::KIND_UNKNOWN;

    // pending token closed by this word
    res_a.kind      = pend_r;
    res_a.start_ofs = ast_pkg::OFS_W'(tstart_r);
    res_a.end_ofs   = ast_pkg::END_W'(pos_r);
    res_a.line      = line_r;
    res_a.col       = scol;
    res_a.err       = ast_pkg::ERR_NONE;
    res_a.last      = 1'b1;

    // token made by the byte itself
    res_b.kind      = ast_pkg::KIND_UNKNOWN;
    res_b.start_ofs = ast_pkg::OFS_W'(pos_r);
    res_b.end_ofs   = ast_pkg::END_W'(pos_p1);
    res_b.line      = line_r;
    res_b.col       = col_r;
    res_b.err       = ast_pkg::ERR_NONE;
    res_b.last      = 1'b1;

    if (!halt_r) begin
      case (mode_r)
        ast_pkg::MODE_WORD: begin
          if (at_end) begin
            halt_nxt   = 1'b1;
            pe         = 1'b1;
            res_a.kind = ast_pkg::KIND_UNKNOWN;
            res_a.err  = ast_pkg::ERR_OPEN_WORD;
          end else if (is_letter(ichar_r)) begin
            pend_nxt = ast_pkg::KIND_IDENT;
            pos_nxt  = pos_p1;
            col_nxt  = col_inc;
          end else if (is_digit(ichar_r)) begin
            pos_nxt = pos_p1;
            col_nxt = col_inc;
          end else begin
            pe       = 1'b1;
            pend_nxt = ast_pkg::KIND_UNKNOWN;
            mode_nxt = ast_pkg::MODE_DEFAULT;
            dc       = 1'b1;
          end
        end
        ast_pkg::MODE_COMMENT: begin
          if (at_end) begin
            pe       = 1'b1;
            pend_nxt = ast_pkg::KIND_UNKNOWN;
            mode_nxt = ast_pkg::MODE_DEFAULT;
            halt_nxt = 1'b1;
          end else if (ichar_r == ast_pkg::CH_NL) begin
            pe       = 1'b1;
            pend_nxt = ast_pkg::KIND_UNKNOWN;
            mode_nxt = ast_pkg::MODE_DEFAULT;
            dc       = 1'b1;
          end else begin
            pos_nxt = pos_p1;
            col_nxt = col_inc;
          end
        end
        default: begin
          mode_nxt = ast_pkg::MODE_DEFAULT;
          if (at_end) halt_nxt = 1'b1;
          else        dc = 1'b1;
        end
      endcase
    end

    if (dc) begin
      mode_nxt = ast_pkg::MODE_DEFAULT;
      if (is_letter(ichar_r) || is_digit(ichar_r)) begin
        mode_nxt   = ast_pkg::MODE_WORD;
        pend_nxt   = is_letter(ichar_r) ? ast_pkg::KIND_IDENT : ast_pkg::KIND_CONST;
        tstart_nxt = pos_r;
        pos_nxt    = pos_p1;
        col_nxt    = col_inc;
      end else begin
        case (ichar_r) inside
          ast_pkg::CH_HASH: begin
            mode_nxt   = ast_pkg::MODE_COMMENT;
            pend_nxt   = ast_pkg::KIND_COMMENT;
            pos_nxt    = pos_p1;
            col_nxt    = col_inc;
            tstart_nxt = pos_p1;
          end
          ast_pkg::CH_NL: begin
            line_nxt   = (line_r < LineMax) ? line_r + 1'b1 : line_r;
            bv         = 1'b1;
            res_b.kind = ast_pkg::KIND_NEWLINE;
            res_b.line = line_nxt;
            res_b.col  = '0;
            pos_nxt    = pos_p1;
            col_nxt    = ast_pkg::COL_W'(1);
          end
          ast_pkg::CH_SPACE, ast_pkg::CH_TAB, ast_pkg::CH_CR: begin
            pos_nxt = pos_p1;
            col_nxt = col_inc;
          end
          ast_pkg::CH_PERIOD, ast_pkg::CH_COMMA, ast_pkg::CH_COLON, ast_pkg::CH_EQUAL,
          ast_pkg::CH_PERCENT, ast_pkg::CH_DOLLAR, ast_pkg::CH_OPEN, ast_pkg::CH_CLOSE: begin
            case (ichar_r)
              ast_pkg::CH_PERIOD:  dkind = ast_pkg::KIND_PERIOD;
              ast_pkg::CH_COMMA:   dkind = ast_pkg::KIND_COMMA;
              ast_pkg::CH_COLON:   dkind = ast_pkg::KIND_COLON;
              ast_pkg::CH_EQUAL:   dkind = ast_pkg::KIND_EQUAL;
              ast_pkg::CH_PERCENT: dkind = ast_pkg::KIND_PERCENT;
              ast_pkg::CH_DOLLAR:  dkind = ast_pkg::KIND_DOLLAR;
              ast_pkg::CH_OPEN:    dkind = ast_pkg::KIND_OPEN;
              default:             dkind = ast_pkg::KIND_CLOSE;
            endcase
            bv         = 1'b1;
            res_b.kind = dkind;
            pos_nxt    = pos_p1;
            col_nxt    = col_inc;
          end
          default: begin
            halt_nxt  = 1'b1;
            bv        = 1'b1;
            res_b.err = ast_pkg::ERR_UNEXPECTED;
          end
        endcase
      end
    end

    res_a.last = res_a.last && !bv;
    res0  = pe ? res_a : res_b;
    res1  = res_b;
    n_res = {1'b0, pe} + {1'b0, bv};
  end

  // queue room check: tokens of the held byte must fit after this cycle's pop
  assign pop       = out_tvalid && out_tready;
  assign base      = count_r - {1'b0, pop};
  assign need      = {1'b0, base} + {1'b0, n_res};
  assign take      = inv_r && (need <= 3'd2);
  assign in_tready = !inv_r || take;

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    count_nxt = base;
    if (take) begin
      count_nxt = need[1:0];
      if (base == 2'd0) begin
        q_nxt[0] = res0;
        q_nxt[1] = res1;
      end else if (base == 2'd1) begin
        q_nxt[1] = res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r    <= 1'b0;
      count_r  <= 2'd0;
      mode_r   <= ast_pkg::MODE_DEFAULT;
      pend_r   <= ast_pkg::KIND_UNKNOWN;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= ast_pkg::LINE_W'(1);
      col_r    <= ast_pkg::COL_W'(1);
      halt_r   <= 1'b0;
    end else begin
      if (in_tready) inv_r <= in_tvalid;
      count_r <= count_nxt;
      if (take) begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        tstart_r <= tstart_nxt;
        pos_r    <= pos_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        halt_r   <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      ichar_r <= in_tdata;
      ieos_r  <= in_tuser;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_tvalid = count_r != 2'd0;
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;
  assign out_tdata  = ast_pkg::TDATA_W'({q_r[0].err, q_r[0].col, q_r[0].line,
                                         q_r[0].end_ofs, q_r[0].start_ofs});

endmodule

// ----- rtl/ast_checker.sv -----
module ast_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ast_pkg::TDATA_W-1:0] out_tdata,
  input logic [ast_pkg::KIND_W-1:0]  out_tuser,
  input logic                        out_tlast
);

  logic [ast_pkg::ERR_W-1:0] err;
  logic [ast_pkg::COL_W-1:0] col;

  assign err = out_tdata[ast_pkg::TD_ERR_LO +: ast_pkg::ERR_W];
  assign col = out_tdata[ast_pkg::TD_COL_LO +: ast_pkg::COL_W];

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("output word changed while stalled");

  // only error words carry the unknown kind, and an error always ends the word group
  a_unknown_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ast_pkg::KIND_UNKNOWN |-> err != ast_pkg::ERR_NONE)
    else $error("unknown token without error code");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err != ast_pkg::ERR_NONE |-> out_tlast
                                             && out_tuser == ast_pkg::KIND_UNKNOWN)
    else $error("error word not last or not unknown kind");

  a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ast_pkg::KIND_NEWLINE |-> col == '0)
    else $error("newline token with nonzero column");

endmodule

bind assembly_source_tokenizer_top ast_checker u_ast_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/assembly_source_tokenizer_top_test.sv -----
module assembly_source_tokenizer_top_test;

  localparam int unsigned MAX_BYTES = ast_pkg::MAX_SOURCE_BYTES_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;   // character
  logic in_tuser = 1'b0;         // end_of_source
  logic out_tvalid;
  logic out_tready = 1'b0;
  // start_offset, end_offset, line_number, column_number, error_code, zero pad
  logic [ast_pkg::TDATA_W-1:0] out_tdata;
  logic [ast_pkg::KIND_W-1:0] out_tuser;  // token_kind
  logic out_tlast;

  assembly_source_tokenizer_top #(
    .MAX_SOURCE_BYTES(MAX_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #25_000_000;
    $display("FAILURE");
    $finish;
  end

  // scanner copy: mode, open token and source position
  logic [1:0] cur_mode = ast_pkg::MODE_DEFAULT;
  logic [ast_pkg::KIND_W-1:0] open_kind = ast_pkg::KIND_UNKNOWN;
  int unsigned word_start = 0;
  int unsigned src_pos = 0;
  int unsigned line_no = 1;
  int unsigned col_no = 1;
  bit stopped = 1'b0;

  ast_pkg::token_t burst[$];
  ast_pkg::token_t tokens_due[$];
  int mismatches = 0;
  int unsigned items_sent = 0;
  bit quiet = 1'b0;
  ast_pkg::token_t got_tok;

  typedef struct packed {
    logic [7:0] ch;
    logic typed;
    ast_pkg::token_t tok;
  } row_t;

  row_t script [26] = '{
    '{ast_pkg::CH_PERIOD, 1'b1, '{ast_pkg::KIND_PERIOD, 16'd0, 17'd1, 16'd1, 16'd1,
                                  ast_pkg::ERR_NONE, 1'b1}},
    '{ast_pkg::CH_CLOSE,  1'b1, '{ast_pkg::KIND_CLOSE, 16'd1, 17'd2, 16'd1, 16'd2,
                                  ast_pkg::ERR_NONE, 1'b1}},
    '{ast_pkg::CH_NL,     1'b1, '{ast_pkg::KIND_NEWLINE, 16'd2, 17'd3, 16'd2, 16'd0,
                                  ast_pkg::ERR_NONE, 1'b1}},
    '{ast_pkg::CH_COMMA, 1'b0, '0}, '{ast_pkg::CH_COLON, 1'b0, '0},
    '{ast_pkg::CH_EQUAL, 1'b0, '0},
    '{ast_pkg::CH_PERCENT, 1'b0, '0}, '{ast_pkg::CH_DOLLAR, 1'b0, '0},
    '{ast_pkg::CH_OPEN, 1'b0, '0},
    '{ast_pkg::CH_SPACE, 1'b0, '0}, '{ast_pkg::CH_TAB, 1'b0, '0},
    '{ast_pkg::CH_CR, 1'b0, '0},
    // constant turning into an identifier, closed by a comma
    '{"0", 1'b0, '0}, '{"9", 1'b0, '0}, '{"A", 1'b0, '0}, '{"z", 1'b0, '0},
    '{"_", 1'b0, '0}, '{ast_pkg::CH_COMMA, 1'b0, '0},
    // constant closed by a comment, comment closed by newline
    '{"5", 1'b0, '0}, '{ast_pkg::CH_HASH, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{ast_pkg::CH_HASH, 1'b0, '0}, '{ast_pkg::CH_NL, 1'b0, '0},
    '{"7", 1'b0, '0}, '{ast_pkg::CH_NL, 1'b0, '0}
  };

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [ast_pkg::KIND_W-1:0] punct_kind(logic [7:0] c);
    case (c)
      ast_pkg::CH_PERIOD:  return ast_pkg::KIND_PERIOD;
      ast_pkg::CH_COMMA:   return ast_pkg::KIND_COMMA;
      ast_pkg::CH_COLON:   return ast_pkg::KIND_COLON;
      ast_pkg::CH_EQUAL:   return ast_pkg::KIND_EQUAL;
      ast_pkg::CH_PERCENT: return ast_pkg::KIND_PERCENT;
      ast_pkg::CH_DOLLAR:  return ast_pkg::KIND_DOLLAR;
      ast_pkg::CH_OPEN:    return ast_pkg::KIND_OPEN;
      ast_pkg::CH_CLOSE:   return ast_pkg::KIND_CLOSE;
      default:             return ast_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  task automatic push_tok(logic [ast_pkg::KIND_W-1:0] kind, int unsigned s, int unsigned e,
                          int unsigned ln, int unsigned cl,
                          logic [ast_pkg::ERR_W-1:0] err);
    ast_pkg::token_t t;
    t.kind = kind;
    t.start_ofs = s[ast_pkg::OFS_W-1:0];
    t.end_ofs = e[ast_pkg::END_W-1:0];
    t.line = ln[ast_pkg::LINE_W-1:0];
    t.col = cl[ast_pkg::COL_W-1:0];
    t.err = err;
    t.last = 1'b0;
    burst.push_back(t);
  endtask

  task automatic bump();
    src_pos++;
    if (col_no < 65535) col_no++;
  endtask

  // column of the open token's first byte, never below 1
  function automatic int unsigned word_col();
    int unsigned len;
    len = src_pos - word_start;
    return (col_no > len) ? col_no - len : 1;
  endfunction

  task automatic close_word();
    push_tok(open_kind, word_start, src_pos, line_no, word_col(), ast_pkg::ERR_NONE);
    open_kind = ast_pkg::KIND_UNKNOWN;
    cur_mode = ast_pkg::MODE_DEFAULT;
  endtask

  task automatic scan_plain(logic [7:0] c);
    logic [ast_pkg::KIND_W-1:0] pk;
    pk = punct_kind(c);
    cur_mode = ast_pkg::MODE_DEFAULT;
    if (is_alpha(c) || is_num(c)) begin
      cur_mode = ast_pkg::MODE_WORD;
      open_kind = is_alpha(c) ? ast_pkg::KIND_IDENT : ast_pkg::KIND_CONST;
      word_start = src_pos;
      bump();
    end else if (c == ast_pkg::CH_HASH) begin
      // comment text starts past the hash
      cur_mode = ast_pkg::MODE_COMMENT;
      open_kind = ast_pkg::KIND_COMMENT;
      bump();
      word_start = src_pos;
    end else if (c == ast_pkg::CH_NL) begin
      if (line_no < 65535) line_no++;
      push_tok(ast_pkg::KIND_NEWLINE, src_pos, src_pos + 1, line_no, 0, ast_pkg::ERR_NONE);
      src_pos++;
      col_no = 1;
    end else if (c == ast_pkg::CH_SPACE || c == ast_pkg::CH_TAB || c == ast_pkg::CH_CR) begin
      bump();
    end else if (pk != ast_pkg::KIND_UNKNOWN) begin
      push_tok(pk, src_pos, src_pos + 1, line_no, col_no, ast_pkg::ERR_NONE);
      bump();
    end else begin
      stopped = 1'b1;
      push_tok(ast_pkg::KIND_UNKNOWN, src_pos, src_pos + 1, line_no, col_no,
               ast_pkg::ERR_UNEXPECTED);
    end
  endtask

  task automatic predict_tokens(logic [7:0] c, logic eos);
    logic at_end;
    ast_pkg::token_t t;
    at_end = eos || src_pos >= MAX_BYTES;
    burst.delete();
    if (!stopped) begin
      case (cur_mode)
        ast_pkg::MODE_WORD: begin
          if (at_end) begin
            stopped = 1'b1;
            push_tok(ast_pkg::KIND_UNKNOWN, word_start, src_pos, line_no, word_col(),
                     ast_pkg::ERR_OPEN_WORD);
          end else if (is_alpha(c)) begin
            open_kind = ast_pkg::KIND_IDENT;
            bump();
          end else if (is_num(c)) begin
            bump();
          end else begin
            close_word();
            scan_plain(c);
          end
        end
        ast_pkg::MODE_COMMENT: begin
          if (at_end) begin
            close_word();
            stopped = 1'b1;
          end else if (c == ast_pkg::CH_NL) begin
            close_word();
            scan_plain(c);
          end else begin
            bump();
          end
        end
        default: begin
          if (at_end) begin
            cur_mode = ast_pkg::MODE_DEFAULT;
            stopped = 1'b1;
          end else begin
            scan_plain(c);
          end
        end
      endcase
    end
    if (burst.size() > 0) begin
      t = burst.pop_back();
      t.last = 1'b1;
      burst.push_back(t);
    end
  endtask

  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_word(logic [7:0] c, logic eos = 1'b0, logic typed = 1'b0,
                           ast_pkg::token_t tok = '0);
    int unsigned n;
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eos;
    do @(posedge clk); while (!in_tready);
    predict_tokens(c, eos);
    if (typed) tokens_due.push_back(tok);
    else foreach (burst[i]) tokens_due.push_back(burst[i]);
    items_sent++;
    n = idle_cycles();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return "A" + r[7:0];
    if (r < 52) return "a" + r[7:0] - 8'd26;
    return "_";
  endfunction

  function automatic logic [7:0] pick_digit();
    int unsigned r;
    r = $urandom_range(0, 9);
    return "0" + r[7:0];
  endfunction

  function automatic logic [7:0] pick_alnum();
    return $urandom_range(0, 1) ? pick_letter() : pick_digit();
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 7))
      0: return ast_pkg::CH_PERIOD;
      1: return ast_pkg::CH_COMMA;
      2: return ast_pkg::CH_COLON;
      3: return ast_pkg::CH_EQUAL;
      4: return ast_pkg::CH_PERCENT;
      5: return ast_pkg::CH_DOLLAR;
      6: return ast_pkg::CH_OPEN;
      default: return ast_pkg::CH_CLOSE;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0: return ast_pkg::CH_SPACE;
      1: return ast_pkg::CH_TAB;
      default: return ast_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ast_pkg::CH_NL);
    return c;
  endfunction

  task automatic send_delim();
    case ($urandom_range(0, 7))
      0, 1, 2: send_word(pick_punct());
      3, 4:    send_word(pick_blank());
      5, 6:    send_word(ast_pkg::CH_NL);
      default: send_word(ast_pkg::CH_HASH);
    endcase
  endtask

  task automatic send_fragment();
    int unsigned r;
    if ($urandom_range(0, 59) == 0) quiet = !quiet;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_word(pick_letter());
      repeat ($urandom_range(0, 7)) send_word(pick_alnum());
      send_delim();
    end else if (r < 45) begin
      repeat ($urandom_range(1, 5)) send_word(pick_digit());
      if ($urandom_range(0, 3) == 0) send_word(pick_letter());
      send_delim();
    end else if (r < 60) begin
      send_word(pick_punct());
    end else if (r < 70) begin
      repeat ($urandom_range(1, 3)) send_word(pick_blank());
    end else if (r < 78) begin
      send_word(ast_pkg::CH_HASH);
      repeat ($urandom_range(0, 12)) send_word(pick_text());
      send_word(ast_pkg::CH_NL);
    end else if (r < 86) begin
      send_word(ast_pkg::CH_NL);
    end else begin
      // loose legal characters in any order
      case ($urandom_range(0, 5))
        0: send_word(pick_letter());
        1: send_word(pick_digit());
        2: send_word(pick_punct());
        3: send_word(pick_blank());
        4: send_word(ast_pkg::CH_NL);
        default: send_word(ast_pkg::CH_HASH);
      endcase
    end
  endtask

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        flag_error($sformatf("token with no expectation, kind %0d", out_tuser));
      end else begin
        got_tok = tokens_due.pop_front();
        cmp_field("kind", 17'(out_tuser), 17'(got_tok.kind));
        cmp_field("start", 17'(out_tdata[ast_pkg::TD_START_LO +: ast_pkg::OFS_W]),
                  17'(got_tok.start_ofs));
        cmp_field("end", out_tdata[ast_pkg::TD_END_LO +: ast_pkg::END_W], got_tok.end_ofs);
        cmp_field("line", 17'(out_tdata[ast_pkg::TD_LINE_LO +: ast_pkg::LINE_W]),
                  17'(got_tok.line));
        cmp_field("column", 17'(out_tdata[ast_pkg::TD_COL_LO +: ast_pkg::COL_W]),
                  17'(got_tok.col));
        cmp_field("error", 17'(out_tdata[ast_pkg::TD_ERR_LO +: ast_pkg::ERR_W]),
                  17'(got_tok.err));
        cmp_field("last", 17'(out_tlast), 17'(got_tok.last));
      end
    end
  end

  // receiver side: ready stretches broken by stalls
  initial begin
    int unsigned n;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      n = idle_cycles();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned end_case;
    logic [7:0] c;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_word(script[i].ch, 1'b0, script[i].typed, script[i].tok);

    while (items_sent < 1500 + $size(script)) send_fragment();

    // the block halts once, so each run closes the source one way
    end_case = $urandom_range(0, 3);
    quiet = 1'b0;
    send_word(ast_pkg::CH_NL);
    case (end_case)
      0: send_word(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_word(ast_pkg::CH_HASH);
        repeat ($urandom_range(0, 4)) send_word(pick_text());
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send_word(pick_alnum());
        send_word(pick_letter());
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        if ($urandom_range(0, 1)) send_word(pick_alnum());
        do c = 8'($urandom_range(0, 255));
        while (is_alpha(c) || is_num(c) || punct_kind(c) != ast_pkg::KIND_UNKNOWN ||
               c == ast_pkg::CH_HASH || c == ast_pkg::CH_NL || c == ast_pkg::CH_SPACE ||
               c == ast_pkg::CH_TAB || c == ast_pkg::CH_CR);
        send_word(c);
      end
    endcase

    // halted: everything is swallowed
    repeat (5) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_word(8'($urandom_range(0, 255)), 1'b1);
    in_tvalid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
